>>> rtl/mtfd_pkg.sv
`timescale 1ns / 1ps
package mtfd_pkg;

	localparam int TABLE_DEPTH  = 144;
	localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
	localparam int MOD_STRIDE   = 48;
	localparam int CH_STRIDE    = 12;
	localparam int STAT_COUNT   = 4;
	localparam int FEAT_LAST    = 11;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_FEATURE = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	localparam logic [1:0] MOD_ACCEL = 2'd0;
	localparam logic [1:0] MOD_GYRO  = 2'd1;
	localparam logic [1:0] MOD_AUDIO = 2'd2;

	localparam logic [1:0] VERDICT_PASS  = 2'd0;
	localparam logic [1:0] VERDICT_VIB   = 2'd1;
	localparam logic [1:0] VERDICT_AUDIO = 2'd2;

	localparam logic [2:0] CFG_MOD_EN     = 3'd0;
	localparam logic [2:0] CFG_ACCEL_AXIS = 3'd1;
	localparam logic [2:0] CFG_GYRO_AXIS  = 3'd2;
	localparam logic [2:0] CFG_AUDIO_CH   = 3'd3;
	localparam logic [2:0] CFG_ACCEL_BAND = 3'd4;
	localparam logic [2:0] CFG_GYRO_BAND  = 3'd5;
	localparam logic [2:0] CFG_AUDIO_BAND = 3'd6;
	localparam logic [2:0] CFG_TRIAL_LIM  = 3'd7;

	localparam logic [15:0] STREAK_MAX = 16'hFFFF;

	typedef struct packed {
		logic       valid;
		logic [1:0] req;
		logic       audio;
		logic       check;
		logic       last;
	} s1_ctl_t;

endpackage

>>> rtl/multimodal_threshold_fault_detector.sv
`timescale 1ns / 1ps
// multimodal threshold fault detector
// input channel (in_valid/in_ready): one request word per cycle while in_ready
// is high, either a threshold write, a feature value or a streak clear.
// thresholds must be written before the feature values that use them.
// config channel (cfg_valid/cfg_ready): always ready, write only while idle.
// output channel (out_valid/out_ready): one verdict word for each feature
// value that closes a slot, written from the compare stage into the output register.
// throughput is one word per cycle while the output register is not stalled:
// the threshold table read is issued at accept into a registered-read ram,
// and the compare plus flag and streak update then go into the output register.
// when the receiver stalls the output register holds its word; the block
// keeps accepting until the compare stage holds a slot-closing word too.
// reset clears flags, streak, pipeline valids and config to defaults; the
// threshold table is not cleared and has no clearing pass.
module multimodal_threshold_fault_detector
	import mtfd_pkg::*;
#(
	parameter int SENSOR_AXES    = 3,
	parameter int AUDIO_CHANNELS = 2,
	parameter int BAND_COUNT     = 8,
	parameter int VALUE_WIDTH    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [1:0]                    modality,
	input  logic [1:0]                    channel,
	input  logic [3:0]                    feature,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          last_of_slot,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    verdict,
	output logic [15:0]                   trial_count,
	output logic                          trigger_source
);

	logic [2:0]  mod_en_q;
	logic [2:0]  accel_axis_q;
	logic [2:0]  gyro_axis_q;
	logic [1:0]  audio_ch_q;
	logic [7:0]  accel_band_q;
	logic [7:0]  gyro_band_q;
	logic [7:0]  audio_band_q;
	logic [15:0] trial_limit_q;

	logic                   in_acc;
	logic                   fields_ok;
	logic [TABLE_AW-1:0]    addr;
	logic                   chk;
	logic [3:0]             ch_mask;
	logic [7:0]             band_mask;
	logic                   mod_on;
	logic                   ch_ok;
	logic                   band_ok;
	logic [2:0]             band;
	logic [VALUE_WIDTH-1:0] thr;

	s1_ctl_t                ctl_s1;
	logic [VALUE_WIDTH-1:0] value_s1;

	logic        s1_res;
	logic        s1_go;
	logic        exceed;
	logic        vib_q;
	logic        aud_q;
	logic        vib_n;
	logic        aud_n;
	logic [15:0] streak_q;
	logic [15:0] streak_inc;
	logic [1:0]  raw;

	logic        out_valid_q;
	logic [1:0]  verdict_q;
	logic [15:0] trial_count_q;
	logic        trigger_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_en_q      <= 3'd0;
			accel_axis_q  <= 3'd7;
			gyro_axis_q   <= 3'd7;
			audio_ch_q    <= 2'd3;
			accel_band_q  <= 8'd0;
			gyro_band_q   <= 8'd0;
			audio_band_q  <= 8'd0;
			trial_limit_q <= 16'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MOD_EN:     mod_en_q      <= cfg_data[2:0];
				CFG_ACCEL_AXIS: accel_axis_q  <= cfg_data[2:0];
				CFG_GYRO_AXIS:  gyro_axis_q   <= cfg_data[2:0];
				CFG_AUDIO_CH:   audio_ch_q    <= cfg_data[1:0];
				CFG_ACCEL_BAND: accel_band_q  <= cfg_data[7:0];
				CFG_GYRO_BAND:  gyro_band_q   <= cfg_data[7:0];
				CFG_AUDIO_BAND: audio_band_q  <= cfg_data[7:0];
				CFG_TRIAL_LIM:  trial_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_acc    = in_valid && in_ready;
	assign fields_ok = (modality != 2'd3) && (feature <= 4'(FEAT_LAST));
	assign addr      = TABLE_AW'(modality) * TABLE_AW'(MOD_STRIDE)
	                 + TABLE_AW'(channel) * TABLE_AW'(CH_STRIDE)
	                 + TABLE_AW'(feature);
	assign band      = 3'(feature - 4'(STAT_COUNT));

	always_comb begin
		mod_on    = 1'b0;
		ch_ok     = 1'b0;
		ch_mask   = 4'd0;
		band_mask = 8'd0;
		case (modality)
			MOD_ACCEL: begin
				mod_on    = mod_en_q[0];
				ch_ok     = {1'b0, channel} < 3'(SENSOR_AXES);
				ch_mask   = {1'b0, accel_axis_q};
				band_mask = accel_band_q;
			end
			MOD_GYRO: begin
				mod_on    = mod_en_q[1];
				ch_ok     = {1'b0, channel} < 3'(SENSOR_AXES);
				ch_mask   = {1'b0, gyro_axis_q};
				band_mask = gyro_band_q;
			end
			MOD_AUDIO: begin
				mod_on    = mod_en_q[2];
				ch_ok     = {1'b0, channel} < 3'(AUDIO_CHANNELS);
				ch_mask   = {2'b00, audio_ch_q};
				band_mask = audio_band_q;
			end
			default: ;
		endcase
		band_ok = (feature < 4'(STAT_COUNT))
		       || (({1'b0, band} < 4'(BAND_COUNT)) && band_mask[band]);
		chk = fields_ok && (req_type == REQ_FEATURE) && mod_on && ch_ok
		   && ch_mask[channel] && band_ok;
	end

	mtfd_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (in_acc && fields_ok && (req_type == REQ_WRITE)),
		.waddr(addr),
		.wdata($unsigned(value)),
		.re   (in_acc && chk),
		.raddr(addr),
		.rdata(thr)
	);

	assign s1_res   = ctl_s1.valid && (ctl_s1.req == REQ_FEATURE) && ctl_s1.last;
	assign s1_go    = ctl_s1.valid && (!s1_res || !out_valid_q || out_ready);
	assign in_ready = !ctl_s1.valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.req   <= req_type;
			ctl_s1.audio <= (modality == MOD_AUDIO);
			ctl_s1.check <= chk;
			ctl_s1.last  <= last_of_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_s1 <= $unsigned(value);
		end
	end

	assign exceed     = ctl_s1.check && ($signed(value_s1) > $signed(thr));
	assign vib_n      = vib_q || (exceed && !ctl_s1.audio);
	assign aud_n      = aud_q || (exceed && ctl_s1.audio);
	assign raw        = vib_n ? VERDICT_VIB : (aud_n ? VERDICT_AUDIO : VERDICT_PASS);
	assign streak_inc = (streak_q == STREAK_MAX) ? streak_q : streak_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vib_q       <= 1'b0;
			aud_q       <= 1'b0;
			streak_q    <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_go) begin
				if (ctl_s1.req == REQ_CLEAR) begin
					streak_q <= 16'd0;
				end
				if (ctl_s1.req == REQ_FEATURE) begin
					vib_q <= vib_n && !ctl_s1.last;
					aud_q <= aud_n && !ctl_s1.last;
				end
				if (s1_res) begin
					out_valid_q <= 1'b1;
					streak_q    <= (raw != VERDICT_PASS) ? streak_inc : 16'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_res) begin
			if (raw != VERDICT_PASS) begin
				verdict_q     <= (streak_inc < trial_limit_q) ? VERDICT_PASS : raw;
				trial_count_q <= streak_inc;
				trigger_q     <= 1'b1;
			end else begin
				verdict_q     <= VERDICT_PASS;
				trial_count_q <= 16'd0;
				trigger_q     <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign trial_count    = trial_count_q;
	assign trigger_source = trigger_q;

endmodule

>>> rtl/mtfd_ram.sv
`timescale 1ns / 1ps
module mtfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mtfd_checker.sv
`timescale 1ns / 1ps
module mtfd_checker
	import mtfd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  verdict,
	input logic [15:0] trial_count,
	input logic        trigger_source
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict)
		&& $stable(trial_count) && $stable(trigger_source))
		else $error("output word changed while stalled");

	a_fail_triggers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict != VERDICT_PASS) |-> trigger_source)
		else $error("failure verdict without trigger");

	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !trigger_source |-> (verdict == VERDICT_PASS) && (trial_count == 16'd0))
		else $error("raw pass with nonzero count or verdict");

	a_trigger_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_source |-> (trial_count != 16'd0)
		&& ((verdict == VERDICT_PASS) || (verdict == VERDICT_VIB) || (verdict == VERDICT_AUDIO)))
		else $error("triggered word with zero streak or bad verdict");

endmodule

bind multimodal_threshold_fault_detector mtfd_checker u_mtfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.verdict       (verdict),
	.trial_count   (trial_count),
	.trigger_source(trigger_source)
);

>>> dv/multimodal_threshold_fault_detector_tb.sv
`timescale 1ns / 1ps
package mtfd_tb_pkg;
	import mtfd_pkg::*;

	localparam int SENSOR_AXES    = 3;
	localparam int AUDIO_CHANNELS = 2;
	localparam int BAND_COUNT     = 8;
	localparam int VALUE_WIDTH    = 32;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] MOD_NONE = 2'd3;

	localparam logic [3:0] FEAT_RMS   = 4'd0;
	localparam logic [3:0] FEAT_KURT  = 4'd1;
	localparam logic [3:0] FEAT_CREST = 4'd2;
	localparam logic [3:0] FEAT_SKEW  = 4'd3;
	localparam logic [3:0] FEAT_NONE  = 4'd15;

	localparam int PRINT_CAP = 50;

	typedef struct packed {
		bit [1:0]  verdict;
		bit [15:0] trials;
		bit        trig;
	} verdict_word_t;

	function automatic int entry_index(bit [1:0] mod, bit [1:0] ch, bit [3:0] feat);
		return mod * MOD_STRIDE + ch * CH_STRIDE + feat;
	endfunction

	class fault_scoreboard;
		bit signed [31:0] thr [TABLE_DEPTH];
		bit vib_flag;
		bit audio_flag;
		bit [15:0] streak;
		bit [2:0] mod_en;
		bit [2:0] accel_axes;
		bit [2:0] gyro_axes;
		bit [1:0] audio_chs;
		bit [7:0] accel_bands;
		bit [7:0] gyro_bands;
		bit [7:0] audio_bands;
		bit [15:0] limit;
		verdict_word_t verdict_q[$];
		int n_words;
		int n_effective;
		int n_checked;
		int n_reported;
		int n_held;
		int n_err;
		bit saturated;

		function new();
			mod_en      = 3'b000;
			accel_axes  = 3'b111;
			gyro_axes   = 3'b111;
			audio_chs   = 2'b11;
			accel_bands = 8'h00;
			gyro_bands  = 8'h00;
			audio_bands = 8'h00;
			limit       = 16'd3;
		endfunction

		function void set_reg(bit [2:0] idx, bit [15:0] data);
			case (idx)
			CFG_MOD_EN:     mod_en = data[2:0];
			CFG_ACCEL_AXIS: accel_axes = data[2:0];
			CFG_GYRO_AXIS:  gyro_axes = data[2:0];
			CFG_AUDIO_CH:   audio_chs = data[1:0];
			CFG_ACCEL_BAND: accel_bands = data[7:0];
			CFG_GYRO_BAND:  gyro_bands = data[7:0];
			CFG_AUDIO_BAND: audio_bands = data[7:0];
			CFG_TRIAL_LIM:  limit = data;
			default: ;
			endcase
		endfunction

		function void check_value(bit [1:0] mod, bit [1:0] ch, bit [3:0] feat,
				bit signed [31:0] val);
			bit [3:0] ch_mask;
			bit [7:0] band_mask;
			int ch_count;
			if (mod == MOD_ACCEL) begin
				ch_mask = {1'b0, accel_axes};
				band_mask = accel_bands;
				ch_count = SENSOR_AXES;
			end else if (mod == MOD_GYRO) begin
				ch_mask = {1'b0, gyro_axes};
				band_mask = gyro_bands;
				ch_count = SENSOR_AXES;
			end else begin
				ch_mask = {2'b00, audio_chs};
				band_mask = audio_bands;
				ch_count = AUDIO_CHANNELS;
			end
			if (!mod_en[mod])
				return;
			if (ch >= ch_count || !ch_mask[ch])
				return;
			if (feat >= STAT_COUNT &&
					(feat - STAT_COUNT >= BAND_COUNT || !band_mask[feat - STAT_COUNT]))
				return;
			if (val > thr[entry_index(mod, ch, feat)]) begin
				if (mod == MOD_AUDIO)
					audio_flag = 1'b1;
				else
					vib_flag = 1'b1;
			end
		endfunction

		function void note_input(bit [1:0] req, bit [1:0] mod, bit [1:0] ch, bit [3:0] feat,
				bit signed [31:0] val, bit last);
			verdict_word_t w;
			bit [1:0] raw;
			bit known;
			known = (mod <= MOD_AUDIO) && (feat <= FEAT_LAST);
			n_words++;
			if (req == REQ_WRITE) begin
				if (known) begin
					thr[entry_index(mod, ch, feat)] = val;
					n_effective++;
				end
			end else if (req == REQ_CLEAR) begin
				streak = 16'd0;
				n_effective++;
			end else if (req == REQ_FEATURE) begin
				n_effective++;
				if (known)
					check_value(mod, ch, feat, val);
				if (last) begin
					raw = vib_flag ? VERDICT_VIB : (audio_flag ? VERDICT_AUDIO : VERDICT_PASS);
					vib_flag = 1'b0;
					audio_flag = 1'b0;
					if (raw != VERDICT_PASS) begin
						if (streak != STREAK_MAX)
							streak++;
						else
							saturated = 1'b1;
						w.verdict = (streak < limit) ? VERDICT_PASS : raw;
						w.trials = streak;
						w.trig = 1'b1;
						if (w.verdict == VERDICT_PASS)
							n_held++;
						else
							n_reported++;
					end else begin
						streak = 16'd0;
						w = '{VERDICT_PASS, 16'd0, 1'b0};
					end
					verdict_q.push_back(w);
				end
			end
		endfunction

		task report_mismatch(string what, int got, int want);
			n_err++;
			if (n_err <= PRINT_CAP)
				$display("mismatch in %s: got %0d, want %0d", what, got, want);
		endtask

		task check_result(bit [1:0] verdict, bit [15:0] trials, bit trig);
			verdict_word_t w;
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected verdict word", verdict, -1);
				return;
			end
			w = verdict_q.pop_front();
			n_checked++;
			if (verdict != w.verdict)
				report_mismatch("verdict", verdict, w.verdict);
			if (trials != w.trials)
				report_mismatch("trial_count", trials, w.trials);
			if (trig != w.trig)
				report_mismatch("trigger_source", trig, w.trig);
		endtask

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

endpackage

module multimodal_threshold_fault_detector_tb;
	import mtfd_pkg::*;
	import mtfd_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PAD_CYCLES     = 4;
	localparam int RANDOM_WORDS   = 1040;
	localparam int PHASE_WORDS    = 120;
	localparam int HOLD_SLOTS     = 40;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [1:0] modality;
	logic [1:0] channel;
	logic [3:0] feature;
	logic signed [VALUE_WIDTH-1:0] value;
	logic last_of_slot;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic out_valid;
	logic out_ready;
	logic [1:0] verdict;
	logic [15:0] trial_count;
	logic trigger_source;

	fault_scoreboard sb;
	int tx_gap_pct;
	int rx_stall_pct;
	int stall_left;
	int idle_cycles;
	int n_cfg;

	multimodal_threshold_fault_detector #(
		.SENSOR_AXES(SENSOR_AXES),
		.AUDIO_CHANNELS(AUDIO_CHANNELS),
		.BAND_COUNT(BAND_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.modality(modality),
		.channel(channel),
		.feature(feature),
		.value(value),
		.last_of_slot(last_of_slot),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.trial_count(trial_count),
		.trigger_source(trigger_source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) < pct)
			return ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(req_type, modality, channel, feature, value, last_of_slot);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(verdict, trial_count, trigger_source);
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap(rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_word(bit [1:0] rt, bit [1:0] mod, bit [1:0] ch, bit [3:0] ft,
			bit signed [31:0] v, bit last);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rt;
		modality     <= mod;
		channel      <= ch;
		feature      <= ft;
		value        <= v;
		last_of_slot <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic cfg_write(bit [2:0] idx, bit [15:0] data, bit [15:0] keep);
		bit [15:0] word;
		// unused upper bits carry junk
		word = (data & keep) | (16'($urandom) & ~keep);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, word);
		n_cfg++;
	endtask

	task automatic apply_config(bit [2:0] en, bit [2:0] aax, bit [2:0] gax, bit [1:0] ach,
			bit [7:0] ab, bit [7:0] gb, bit [7:0] aub, bit [15:0] lim);
		cfg_write(CFG_MOD_EN, 16'(en), 16'h0007);
		cfg_write(CFG_ACCEL_AXIS, 16'(aax), 16'h0007);
		cfg_write(CFG_GYRO_AXIS, 16'(gax), 16'h0007);
		cfg_write(CFG_AUDIO_CH, 16'(ach), 16'h0003);
		cfg_write(CFG_ACCEL_BAND, 16'(ab), 16'h00FF);
		cfg_write(CFG_GYRO_BAND, 16'(gb), 16'h00FF);
		cfg_write(CFG_AUDIO_BAND, 16'(aub), 16'h00FF);
		cfg_write(CFG_TRIAL_LIM, lim, 16'hFFFF);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (PAD_CYCLES) @(posedge clk);
	endtask

	function automatic bit signed [31:0] rand_q16();
		case ($urandom_range(9))
		0: return 32'sh7FFFFFFF;
		1: return 32'sh80000000;
		2: return 32'sd0;
		3, 4: return $urandom;
		default: return int'($urandom_range(32'h80000)) - 32'sh40000;
		endcase
	endfunction

	// about half the probes sit on or next to the stored threshold
	function automatic bit signed [31:0] probe_value(bit [1:0] mod, bit [1:0] ch, bit [3:0] ft);
		bit signed [31:0] t;
		if (mod <= MOD_AUDIO && ft <= FEAT_LAST && $urandom_range(1)) begin
			t = sb.thr[entry_index(mod, ch, ft)];
			case ($urandom_range(2))
			0: return t;
			1: return t + 1;
			default: return t - 1;
			endcase
		end
		return rand_q16();
	endfunction

	task automatic send_slot();
		int n;
		bit [1:0] mod;
		bit [1:0] ch;
		bit [3:0] ft;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			mod = ($urandom_range(19) == 0) ? MOD_NONE : 2'($urandom_range(MOD_AUDIO));
			ch = 2'($urandom_range(3));
			ft = ($urandom_range(14) == 0) ? 4'($urandom_range(FEAT_LAST + 1, FEAT_NONE))
				: 4'($urandom_range(FEAT_LAST));
			send_word(REQ_FEATURE, mod, ch, ft, probe_value(mod, ch, ft), i == n - 1);
		end
	endtask

	task automatic send_noise();
		bit [1:0] mod;
		bit [3:0] ft;
		case ($urandom_range(9))
		0, 1, 2, 3, 4: begin
			mod = ($urandom_range(9) == 0) ? MOD_NONE : 2'($urandom_range(MOD_AUDIO));
			ft = ($urandom_range(9) == 0) ? 4'($urandom_range(FEAT_LAST + 1, FEAT_NONE))
				: 4'($urandom_range(FEAT_LAST));
			send_word(REQ_WRITE, mod, 2'($urandom_range(3)), ft, rand_q16(),
				1'($urandom_range(1)));
		end
		5, 6: send_word(REQ_CLEAR, 2'($urandom), 2'($urandom), 4'($urandom), $urandom,
			1'($urandom_range(1)));
		7: send_word(REQ_NONE, 2'($urandom), 2'($urandom), 4'($urandom), $urandom,
			1'($urandom_range(1)));
		default: begin
			mod = 2'($urandom_range(MOD_AUDIO));
			ft = 4'($urandom_range(FEAT_LAST));
			send_word(REQ_FEATURE, mod, 2'($urandom_range(3)), ft, probe_value(mod, 2'd0, ft),
				1'b0);
		end
		endcase
	endtask

	function automatic bit [7:0] rand_mask8();
		return $urandom_range(1) ? 8'hFF : 8'($urandom);
	endfunction

	function automatic bit [15:0] rand_limit();
		case ($urandom_range(9))
		0: return 16'd0;
		1: return STREAK_MAX;
		2: return 16'($urandom);
		default: return 16'($urandom_range(1, 4));
		endcase
	endfunction

	initial begin
		int phase;
		int random_base;
		int phase_base;
		sb = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_WRITE;
		modality     = MOD_ACCEL;
		channel      = 2'd0;
		feature      = FEAT_RMS;
		value        = '0;
		last_of_slot = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_MOD_EN;
		cfg_data     = 16'd0;
		out_ready    = 1'b0;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		stall_left   = 0;
		idle_cycles  = 0;
		n_cfg        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table at reset settings
		for (int m = 0; m <= MOD_AUDIO; m++)
			for (int c = 0; c < 4; c++)
				for (int f = 0; f <= FEAT_LAST; f++)
					send_word(REQ_WRITE, 2'(m), 2'(c), 4'(f), rand_q16(),
						1'($urandom_range(1)));
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sh7FFFFFFF, 1'b1);
		drain();

		apply_config(3'b111, 3'b111, 3'b111, 2'b11, 8'hFF, 8'hFF, 8'hFF, 16'd2);
		send_word(REQ_WRITE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sd0, 1'b0);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sd0, 1'b1);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sd1, 1'b1);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_WRITE, MOD_AUDIO, 2'd1, FEAT_LAST, 32'sh80000000, 1'b1);
		send_word(REQ_FEATURE, MOD_AUDIO, 2'd1, FEAT_LAST, 32'sh80000000, 1'b1);
		send_word(REQ_FEATURE, MOD_AUDIO, 2'd1, FEAT_LAST, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_CLEAR, MOD_AUDIO, 2'd1, FEAT_LAST, 32'sd0, 1'b0);
		send_word(REQ_FEATURE, MOD_AUDIO, 2'd1, FEAT_LAST, 32'sh7FFFFFFF, 1'b1);
		// vibration beats audio in one slot
		send_word(REQ_WRITE, MOD_GYRO, 2'd2, FEAT_KURT, 32'sh80000000, 1'b0);
		send_word(REQ_WRITE, MOD_AUDIO, 2'd0, FEAT_CREST, 32'sh80000000, 1'b0);
		send_word(REQ_FEATURE, MOD_AUDIO, 2'd0, FEAT_CREST, 32'sh7FFFFFFF, 1'b0);
		send_word(REQ_FEATURE, MOD_GYRO, 2'd2, FEAT_KURT, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_WRITE, MOD_NONE, 2'd3, FEAT_NONE, 32'sd0, 1'b1);
		send_word(REQ_FEATURE, MOD_NONE, 2'd0, FEAT_RMS, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_NONE, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd3, FEAT_SKEW, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_FEATURE, MOD_AUDIO, 2'd2, FEAT_RMS, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_NONE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_FEATURE, MOD_GYRO, 2'd1, FEAT_SKEW, 32'sh7FFFFFFF, 1'b1);
		send_word(REQ_FEATURE, MOD_GYRO, 2'd0, 4'(STAT_COUNT), 32'sh7FFFFFFF, 1'b1);
		drain();

		phase = 0;
		random_base = sb.n_effective;
		while (sb.n_effective - random_base < RANDOM_WORDS) begin
			case (phase)
			0: apply_config(3'b000, 3'b000, 3'b000, 2'b00, 8'h00, 8'h00, 8'h00, 16'd0);
			1: apply_config(3'b111, 3'b111, 3'b111, 2'b11, 8'hFF, 8'hFF, 8'hFF, STREAK_MAX);
			2: apply_config(3'b111, 3'b111, 3'b111, 2'b11, 8'hFF, 8'hFF, 8'hFF, 16'd1);
			3: apply_config(3'b111, 3'b111, 3'b111, 2'b11, 8'hFF, 8'hFF, 8'hFF, 16'd0);
			default: apply_config($urandom_range(1) ? 3'b111 : 3'($urandom),
				$urandom_range(1) ? 3'b111 : 3'($urandom),
				$urandom_range(1) ? 3'b111 : 3'($urandom),
				$urandom_range(1) ? 2'b11 : 2'($urandom),
				rand_mask8(), rand_mask8(), rand_mask8(), rand_limit());
			endcase
			case ($urandom_range(3))
			0: tx_gap_pct = 0;
			1: tx_gap_pct = 15;
			2: tx_gap_pct = 40;
			default: tx_gap_pct = 70;
			endcase
			case ($urandom_range(3))
			0: rx_stall_pct = 0;
			1: rx_stall_pct = 15;
			2: rx_stall_pct = 40;
			default: rx_stall_pct = 70;
			endcase
			phase_base = sb.n_effective;
			while (sb.n_effective - phase_base < PHASE_WORDS &&
					sb.n_effective - random_base < RANDOM_WORDS) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					send_slot();
			end
			drain();
			phase++;
		end

		// long failing run held back by the top limit, then a pass resets it
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		apply_config(3'b001, 3'b001, 3'b000, 2'b00, 8'h00, 8'h00, 8'h00, STREAK_MAX);
		send_word(REQ_CLEAR, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sd0, 1'b0);
		send_word(REQ_WRITE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sh80000000, 1'b0);
		repeat (HOLD_SLOTS)
			send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sd0, 1'b1);
		send_word(REQ_FEATURE, MOD_ACCEL, 2'd0, FEAT_RMS, 32'sh80000000, 1'b1);
		drain();

		$display("%0d request words over %0d random phases, %0d register writes, %0d verdicts",
			sb.n_words, phase, n_cfg, sb.n_checked);
		$display("%0d failures reported, %0d held back, streak saturation %s",
			sb.n_reported, sb.n_held, sb.saturated ? "reached" : "missed");
		if (sb.n_err == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mtfd_pkg.sv
rtl/mtfd_ram.sv
rtl/multimodal_threshold_fault_detector.sv
rtl/mtfd_checker.sv
dv/multimodal_threshold_fault_detector_tb.sv
